[hw/rtl/cowa_pkg.sv]
// shared constants and types of the clock offset window averager
package cowa_pkg;

	localparam int WINDOW = 16;
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int TIME_W = 64;
	localparam int SUM_W = 32;
	localparam int DIV_STEPS = SUM_W / 2;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam logic [TIME_W-1:0] GAP_LIMIT_RESET = 64'd10000000000;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STORE,
		ST_SETUP,
		ST_BASE,
		ST_ACC,
		ST_DIV,
		ST_WAIT,
		ST_DONE
	} state_t;

	// request into the divider
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	// answer from the divider
	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

[hw/rtl/clock_offset_window_average.sv]
// Host-to-local clock offset averager over a ring of 16 offsets. Each input
// transaction carries a host and a local time stamp; if the host time moved on
// by more than gap_limit since the last sample the window restarts empty. The
// offset host minus local goes into the ring and one output transaction returns
// the window average and the sample count. The ring has one read port, so the
// slots are summed one per cycle, and the division by the count runs in an
// iterative divider that retires two quotient bits per cycle. The input is not
// ready while an item is at work; a finished result waits in the output
// register while the next item is accepted.
module clock_offset_window_average (
	input  logic         clk,
	input  logic         arst_n,
	// configuration: gap_limit
	input  logic         cfg_we,
	input  logic [63:0]  cfg_data,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // host_time[63:0], local_time[127:64]
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata   // avg_offset[63:0], sample_count[68:64], zero fill
);

	localparam int TW = cowa_pkg::TIME_W;
	localparam int SW = cowa_pkg::SLOT_W;
	localparam int CW = cowa_pkg::CNT_W;
	localparam int MW = cowa_pkg::SUM_W;

	cowa_pkg::state_t state_q, state_d;

	logic [TW-1:0] gap_q;
	logic [TW-1:0] prev_q;
	logic [TW-1:0] host_q;
	logic [TW-1:0] local_q;
	logic [SW-1:0] slot_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] rd_idx_q;
	logic [SW-1:0] acc_idx_q;
	logic [TW-1:0] base_q;
	logic [MW-1:0] sum_q;
	logic [MW-1:0] quo_q;
	logic [TW-1:0] avg_q;
	logic [CW-1:0] out_cnt_q;
	logic          out_valid_q;

	logic          ring_we;
	logic [TW-1:0] ring_rdata;
	logic          restart;
	logic [SW-1:0] wr_slot;
	logic [CW-1:0] base_cnt;
	logic [SW-1:0] last_idx;
	logic          out_free;

	cowa_pkg::div_req_t div_req;
	cowa_pkg::div_rsp_t div_rsp;

	// window restart check and slot choice
	assign restart = (host_q - prev_q) > gap_q;
	assign wr_slot = restart ? '0 : slot_q;
	assign base_cnt = restart ? '0 : count_q;
	assign last_idx = SW'(count_q - 1'b1);
	assign out_free = !out_valid_q || m_tready;

	cowa_ring u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wr_slot),
		.wdata (host_q - local_q),
		.raddr (rd_idx_q),
		.rdata (ring_rdata)
	);

	cowa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cowa_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = cowa_pkg::ST_STORE;
			end
			cowa_pkg::ST_STORE: state_d = cowa_pkg::ST_SETUP;
			cowa_pkg::ST_SETUP: state_d = cowa_pkg::ST_BASE;
			cowa_pkg::ST_BASE: begin
				state_d = (count_q == CW'(1)) ? cowa_pkg::ST_DIV : cowa_pkg::ST_ACC;
			end
			cowa_pkg::ST_ACC: begin
				if (acc_idx_q == last_idx) state_d = cowa_pkg::ST_DIV;
			end
			cowa_pkg::ST_DIV: state_d = cowa_pkg::ST_WAIT;
			cowa_pkg::ST_WAIT: begin
				if (div_rsp.done) state_d = cowa_pkg::ST_DONE;
			end
			cowa_pkg::ST_DONE: begin
				if (out_free) state_d = cowa_pkg::ST_IDLE;
			end
			default: state_d = cowa_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		ring_we = 1'b0;
		div_req.start = 1'b0;
		div_req.dividend = sum_q;
		div_req.divisor = count_q;
		unique case (state_q)
			cowa_pkg::ST_IDLE:  s_tready = 1'b1;
			cowa_pkg::ST_STORE: ring_we = 1'b1;
			cowa_pkg::ST_DIV:   div_req.start = 1'b1;
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cowa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= cowa_pkg::GAP_LIMIT_RESET;
		end else if (cfg_we) begin
			gap_q <= cfg_data;
		end
	end

	// window state kept across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			slot_q <= '0;
			count_q <= '0;
		end else if (state_q == cowa_pkg::ST_STORE) begin
			prev_q <= host_q;
			slot_q <= (wr_slot == SW'(cowa_pkg::WINDOW - 1)) ? '0 : wr_slot + 1'b1;
			count_q <= (base_cnt < CW'(cowa_pkg::WINDOW)) ? base_cnt + 1'b1 : base_cnt;
		end
	end

	// input capture, slot walk and sum
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			host_q <= s_tdata[63:0];
			local_q <= s_tdata[127:64];
		end
		unique case (state_q)
			cowa_pkg::ST_STORE: rd_idx_q <= '0;
			cowa_pkg::ST_SETUP: rd_idx_q <= SW'(1);
			cowa_pkg::ST_BASE: begin
				base_q <= ring_rdata;
				sum_q <= '0;
				rd_idx_q <= rd_idx_q + 1'b1;
				acc_idx_q <= SW'(1);
			end
			cowa_pkg::ST_ACC: begin
				sum_q <= sum_q + (ring_rdata[MW-1:0] - base_q[MW-1:0]);
				rd_idx_q <= rd_idx_q + 1'b1;
				acc_idx_q <= acc_idx_q + 1'b1;
			end
			cowa_pkg::ST_WAIT: begin
				if (div_rsp.done) quo_q <= div_rsp.quotient;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == cowa_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cowa_pkg::ST_DONE && out_free) begin
			avg_q <= base_q + {{(TW - MW){quo_q[MW-1]}}, quo_q};
			out_cnt_q <= count_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, out_cnt_q, avg_q};

endmodule

[hw/rtl/cowa_ring.sv]
// ring of offset slots with one write port and one registered read port
module cowa_ring (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [cowa_pkg::SLOT_W-1:0]            waddr,
	input  logic [cowa_pkg::TIME_W-1:0]            wdata,
	input  logic [cowa_pkg::SLOT_W-1:0]            raddr,
	output logic [cowa_pkg::TIME_W-1:0]            rdata
);

	logic [cowa_pkg::TIME_W-1:0] mem_q [cowa_pkg::WINDOW];
	logic [cowa_pkg::TIME_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/cowa_div.sv]
// iterative signed divider, two quotient bits per cycle, truncating toward zero
module cowa_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cowa_pkg::div_req_t   req,
	output cowa_pkg::div_rsp_t   rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic                              neg_q;
	logic [cowa_pkg::STEP_W-1:0]       cnt_q;
	logic [cowa_pkg::CNT_W-1:0]        div_q;
	logic [cowa_pkg::CNT_W-1:0]        rem_q;
	logic [cowa_pkg::SUM_W-1:0]        dq_q;
	logic [cowa_pkg::SUM_W-1:0]        mag;
	logic [cowa_pkg::CNT_W:0]          step1;
	logic [cowa_pkg::CNT_W:0]          step2;

	// one restoring step: returns {quotient bit, new remainder}
	function automatic logic [cowa_pkg::CNT_W:0] div_step(
		input logic [cowa_pkg::CNT_W-1:0] rem,
		input logic                       bitin,
		input logic [cowa_pkg::CNT_W-1:0] d
	);
		logic [cowa_pkg::CNT_W:0] t;
		logic [cowa_pkg::CNT_W:0] dd;
		logic [cowa_pkg::CNT_W:0] r;
		t = {rem, bitin};
		dd = {1'b0, d};
		if (t >= dd) begin
			r = t - dd;
			div_step = {1'b1, r[cowa_pkg::CNT_W-1:0]};
		end else begin
			div_step = {1'b0, t[cowa_pkg::CNT_W-1:0]};
		end
	endfunction

	// magnitude of the dividend
	assign mag = req.dividend[cowa_pkg::SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;

	// two chained steps per cycle
	assign step1 = div_step(rem_q, dq_q[cowa_pkg::SUM_W-1], div_q);
	assign step2 = div_step(step1[cowa_pkg::CNT_W-1:0], dq_q[cowa_pkg::SUM_W-2], div_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cowa_pkg::STEP_W'(cowa_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[cowa_pkg::SUM_W-1];
			div_q <= req.divisor;
			rem_q <= '0;
			dq_q <= mag;
		end else if (busy_q) begin
			rem_q <= step2[cowa_pkg::CNT_W-1:0];
			dq_q <= {dq_q[cowa_pkg::SUM_W-3:0], step1[cowa_pkg::CNT_W], step2[cowa_pkg::CNT_W]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = neg_q ? (~dq_q + 1'b1) : dq_q;

endmodule
